// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers; clk and rst_n are taken from the using module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define PNPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PNPA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PNPA_ASSERT(lbl, prop, msg)
`define PNPA_NEVER(lbl, cond, msg)
`endif

`endif

// ===== sv/pnpa_pkg.sv =====
// ---------------------------------------------------------------------------
// pnpa_pkg
// Types, constants and saturating Q arithmetic for the 1PN pair core.
// ---------------------------------------------------------------------------
`default_nettype none

package pnpa_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QW        = 32;
  localparam int CFG_W     = 31;

  localparam int FRONT_LAT = 5;
  localparam int SQRT_LAT  = 32;
  localparam int MID_LAT   = 2;
  localparam int DIV_LAT   = 34;
  localparam int BACK_LAT  = 11;
  localparam int LATENCY   = FRONT_LAT + SQRT_LAT + MID_LAT + DIV_LAT + BACK_LAT;

  localparam logic [0:0] REG_GRAV   = 1'b0;
  localparam logic [0:0] REG_INV_C2 = 1'b1;

  localparam logic [1:0] AXIS_Y = 2'd2;

  localparam logic [CFG_W-1:0] CFG_ONE = CFG_W'(1 << FRAC_BITS);

  localparam logic signed [63:0] QMAX64 = 64'sd2147483647;
  localparam logic signed [63:0] QMIN64 = -64'sd2147483648;

  typedef logic signed [QW-1:0] q_t;

  localparam q_t Q_MAX          = 32'sh7fffffff;
  localparam q_t Q_MIN          = 32'sh80000000;
  localparam q_t C_THREE_HALVES = QW'(3 << (FRAC_BITS - 1));

  typedef struct packed {
    q_t          pos1_x;
    q_t          pos1_y;
    q_t          pos2_x;
    q_t          pos2_y;
    q_t          vel1_x;
    q_t          vel1_y;
    q_t          vel2_x;
    q_t          vel2_y;
    logic [30:0] mass1;
    logic [30:0] mass2;
    logic [1:0]  axis;
  } pnpa_in_t;

  typedef struct packed {
    q_t   accel;
    logic zero_separation;
  } pnpa_out_t;

  typedef struct packed {
    logic zero;
    logic use_y;
    q_t   dx;
    q_t   dy;
    q_t   v1x;
    q_t   v1y;
    q_t   v2x;
    q_t   v2y;
    q_t   v_c;
    q_t   v1s;
    q_t   v2s;
    q_t   cv;
    q_t   grav;
    q_t   gm2;
    q_t   a1n;
    q_t   a2n;
    q_t   m1;
    q_t   m2;
    q_t   icc;
  } side_t;

  function automatic q_t sat64(input logic signed [63:0] v);
    q_t r;
    if (v > QMAX64) begin
      r = Q_MAX;
    end else if (v < QMIN64) begin
      r = Q_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat64(p >>> FRAC_BITS);
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    return sat64(64'(a) + 64'(b));
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    return sat64(64'(a) - 64'(b));
  endfunction

  function automatic q_t qneg(input q_t a);
    return sat64(-64'(a));
  endfunction

  function automatic q_t qscale(input q_t a, input logic signed [3:0] k);
    return sat64(64'(a) * 64'(k));
  endfunction

  function automatic q_t ext_u(input logic [30:0] x);
    return q_t'({1'b0, x});
  endfunction

endpackage

`default_nettype wire

// ===== sv/pnpa_isqrt.sv =====
// ---------------------------------------------------------------------------
// pnpa_isqrt
// Pipelined integer square root of a 64-bit radicand, one result bit a stage.
// ---------------------------------------------------------------------------
`default_nettype none

module pnpa_isqrt (
  input  logic        clk,
  input  logic [63:0] radicand,
  output logic [32:0] root
);
  import pnpa_pkg::*;

  logic [63:0] x_r   [SQRT_LAT];
  logic [63:0] res_r [SQRT_LAT];

  for (genvar i = 0; i < SQRT_LAT; i++) begin : g_stage
    localparam logic [63:0] BITV = 64'd1 << (62 - 2 * i);
    logic [63:0] x_in, res_in, trial, x_nxt, res_nxt;

    if (i == 0) begin : g_first
      assign x_in   = radicand;
      assign res_in = '0;
    end else begin : g_next
      assign x_in   = x_r[i-1];
      assign res_in = res_r[i-1];
    end

    always_comb begin
      trial = res_in + BITV;
      if (x_in >= trial) begin
        x_nxt   = x_in - trial;
        res_nxt = (res_in >> 1) + BITV;
      end else begin
        x_nxt   = x_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      x_r[i]   <= x_nxt;
      res_r[i] <= res_nxt;
    end
  end

  assign root = res_r[SQRT_LAT-1][32:0];

endmodule

`default_nettype wire

// ===== sv/pnpa_qdiv.sv =====
// ---------------------------------------------------------------------------
// pnpa_qdiv
// Pipelined saturating Q divide: (num << FRAC_BITS) / den, toward zero.
// ---------------------------------------------------------------------------
`default_nettype none

module pnpa_qdiv (
  input  logic           clk,
  input  pnpa_pkg::q_t   num,
  input  pnpa_pkg::q_t   den,
  output pnpa_pkg::q_t   quo
);
  import pnpa_pkg::*;

  localparam int NB = QW;

  typedef struct packed {
    logic [NB-1:0] rem;
    logic [NB-1:0] q;
    logic [NB-1:0] ua;
    logic [NB-1:0] ub;
    logic          neg;
    logic          az;
    logic          bz;
    logic          an;
    logic          ovf;
  } dst_t;

  dst_t st_r [NB+1];
  dst_t prep_nxt;
  q_t   quo_nxt;
  q_t   quo_r;

  always_comb begin
    prep_nxt     = '0;
    prep_nxt.ua  = num[NB-1] ? unsigned'(-num) : unsigned'(num);
    prep_nxt.ub  = den[NB-1] ? unsigned'(-den) : unsigned'(den);
    prep_nxt.neg = num[NB-1] ^ den[NB-1];
    prep_nxt.an  = num[NB-1];
    prep_nxt.az  = (num == '0);
    prep_nxt.bz  = (den == '0);
    prep_nxt.rem = prep_nxt.ua >> (NB - FRAC_BITS);
    prep_nxt.ovf = (prep_nxt.ua >> (NB - FRAC_BITS)) >= prep_nxt.ub;
  end

  always_ff @(posedge clk) begin
    st_r[0] <= prep_nxt;
  end

  for (genvar j = 0; j < NB; j++) begin : g_bit
    logic        nbit;
    logic [NB:0] sh;
    logic        ge;
    dst_t        nxt;

    if ((NB - 1 - j) >= FRAC_BITS) begin : g_num
      assign nbit = st_r[j].ua[NB-1-j-FRAC_BITS];
    end else begin : g_pad
      assign nbit = 1'b0;
    end

    always_comb begin
      sh      = {st_r[j].rem, nbit};
      ge      = sh >= {1'b0, st_r[j].ub};
      nxt     = st_r[j];
      nxt.rem = ge ? NB'(sh - {1'b0, st_r[j].ub}) : sh[NB-1:0];
      nxt.q   = {st_r[j].q[NB-2:0], ge};
    end

    always_ff @(posedge clk) begin
      st_r[j+1] <= nxt;
    end
  end

  always_comb begin
    if (st_r[NB].az) begin
      quo_nxt = '0;
    end else if (st_r[NB].bz) begin
      quo_nxt = st_r[NB].an ? Q_MIN : Q_MAX;
    end else if (st_r[NB].ovf || st_r[NB].q[NB-1]) begin
      quo_nxt = st_r[NB].neg ? Q_MIN : Q_MAX;
    end else if (st_r[NB].neg) begin
      quo_nxt = -signed'(st_r[NB].q);
    end else begin
      quo_nxt = signed'(st_r[NB].q);
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
  end

  assign quo = quo_r;

endmodule

`default_nettype wire

// ===== sv/pnpa_front.sv =====
// ---------------------------------------------------------------------------
// pnpa_front
// Entry stages: separation, squared distance, speed terms, G products.
// ---------------------------------------------------------------------------
`default_nettype none

module pnpa_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  pnpa_pkg::pnpa_in_t           in_data,
  input  logic [pnpa_pkg::CFG_W-1:0]   grav,
  input  logic [pnpa_pkg::CFG_W-1:0]   inv_c2,
  output logic                         out_valid,
  output pnpa_pkg::side_t              out_side,
  output logic [63:0]                  out_sum
);
  import pnpa_pkg::*;

  logic [FRONT_LAT-1:0] vld_r;
  logic signed [32:0]   rdx, rdy;
  side_t                sd1_nxt, sd2_nxt, sd3_nxt, sd5_nxt;
  side_t                sd1_r, sd2_r, sd3_r, sd4_r, sd5_r;
  logic signed [63:0]   dx2_r, dy2_r;
  q_t                   p11x_r, p11y_r, p22x_r, p22y_r, p12x_r, p12y_r;
  q_t                   g2_r, g2m1_r, g2m2_r, t1_r, t2_r;
  logic [63:0]          sum3_r, sum4_r, sum5_r;

  always_comb begin
    rdx           = 33'(in_data.pos1_x) - 33'(in_data.pos2_x);
    rdy           = 33'(in_data.pos1_y) - 33'(in_data.pos2_y);
    sd1_nxt       = '0;
    sd1_nxt.zero  = (rdx == '0) && (rdy == '0);
    sd1_nxt.use_y = (in_data.axis == AXIS_Y);
    sd1_nxt.dx    = sat64(64'(rdx));
    sd1_nxt.dy    = sat64(64'(rdy));
    sd1_nxt.v1x   = in_data.vel1_x;
    sd1_nxt.v1y   = in_data.vel1_y;
    sd1_nxt.v2x   = in_data.vel2_x;
    sd1_nxt.v2y   = in_data.vel2_y;
    sd1_nxt.v_c   = sd1_nxt.use_y ? qsub(in_data.vel1_y, in_data.vel2_y)
                                  : qsub(in_data.vel1_x, in_data.vel2_x);
    sd1_nxt.m1    = ext_u(in_data.mass1);
    sd1_nxt.m2    = ext_u(in_data.mass2);
    sd1_nxt.grav  = ext_u(grav);
    sd1_nxt.icc   = ext_u(inv_c2);
  end

  always_comb begin
    sd2_nxt     = sd1_r;
    sd2_nxt.gm2 = qmul(sd1_r.grav, sd1_r.m2);

    sd3_nxt     = sd2_r;
    sd3_nxt.v1s = qadd(p11x_r, p11y_r);
    sd3_nxt.v2s = qadd(p22x_r, p22y_r);
    sd3_nxt.cv  = qadd(p12x_r, p12y_r);

    sd5_nxt     = sd4_r;
    sd5_nxt.a1n = qscale(t1_r, 4'sd5);
    sd5_nxt.a2n = qscale(t2_r, 4'sd4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[FRONT_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    sd1_r <= sd1_nxt;

    sd2_r     <= sd2_nxt;
    dx2_r     <= 64'(sd1_r.dx) * 64'(sd1_r.dx);
    dy2_r     <= 64'(sd1_r.dy) * 64'(sd1_r.dy);
    p11x_r    <= qmul(sd1_r.v1x, sd1_r.v1x);
    p11y_r    <= qmul(sd1_r.v1y, sd1_r.v1y);
    p22x_r    <= qmul(sd1_r.v2x, sd1_r.v2x);
    p22y_r    <= qmul(sd1_r.v2y, sd1_r.v2y);
    p12x_r    <= qmul(sd1_r.v1x, sd1_r.v2x);
    p12y_r    <= qmul(sd1_r.v1y, sd1_r.v2y);
    g2_r      <= qmul(sd1_r.grav, sd1_r.grav);

    sd3_r     <= sd3_nxt;
    sum3_r    <= unsigned'(dx2_r) + unsigned'(dy2_r);
    g2m1_r    <= qmul(g2_r, sd2_r.m1);
    g2m2_r    <= qmul(g2_r, sd2_r.m2);

    sd4_r  <= sd3_r;
    sum4_r <= sum3_r;
    t1_r   <= qmul(g2m1_r, sd3_r.m2);
    t2_r   <= qmul(g2m2_r, sd3_r.m2);

    sd5_r     <= sd5_nxt;
    sum5_r    <= sum4_r;
  end

  assign out_valid = vld_r[FRONT_LAT-1];
  assign out_side  = sd5_r;
  assign out_sum   = sum5_r;

endmodule

`default_nettype wire

// ===== sv/pnpa_back.sv =====
// ---------------------------------------------------------------------------
// pnpa_back
// Tail stages: projections, 1PN coefficients, final sum and zero override.
// ---------------------------------------------------------------------------
`default_nettype none

module pnpa_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  pnpa_pkg::side_t     in_side,
  input  pnpa_pkg::q_t        nx,
  input  pnpa_pkg::q_t        ny,
  input  pnpa_pkg::q_t        k,
  input  pnpa_pkg::q_t        a1,
  input  pnpa_pkg::q_t        a2,
  output logic                out_valid,
  output pnpa_pkg::pnpa_out_t out_data
);
  import pnpa_pkg::*;

  typedef struct packed {
    logic zero;
    q_t   k;
    q_t   nc;
    q_t   vc;
    q_t   v1s;
    q_t   v2s;
    q_t   cv;
    q_t   icc;
    q_t   a12;
    q_t   kn;
    q_t   pa;
    q_t   pb;
    q_t   pc;
    q_t   pd;
    q_t   nv1;
    q_t   nv2;
    q_t   newton;
    q_t   nv2sq;
    q_t   dv;
    q_t   br0;
    q_t   cvv;
    q_t   br;
    q_t   pv;
    q_t   kbr;
    q_t   cn;
    q_t   pn1;
    q_t   sm;
    q_t   pn;
  } bk_t;

  logic [BACK_LAT-1:0] vld_r;
  bk_t                 c_nxt [BACK_LAT-1];
  bk_t                 c_r [BACK_LAT-1];
  pnpa_out_t           out_nxt;
  pnpa_out_t           out_r;

  always_comb begin
    c_nxt[0]      = '0;
    c_nxt[0].zero = in_side.zero;
    c_nxt[0].k    = k;
    c_nxt[0].nc   = in_side.use_y ? ny : nx;
    c_nxt[0].vc   = in_side.v_c;
    c_nxt[0].v1s  = in_side.v1s;
    c_nxt[0].v2s  = in_side.v2s;
    c_nxt[0].cv   = in_side.cv;
    c_nxt[0].icc  = in_side.icc;
    c_nxt[0].a12  = qadd(a1, a2);
    c_nxt[0].kn   = qmul(k, c_nxt[0].nc);
    c_nxt[0].pa   = qmul(nx, in_side.v1x);
    c_nxt[0].pb   = qmul(ny, in_side.v1y);
    c_nxt[0].pc   = qmul(nx, in_side.v2x);
    c_nxt[0].pd   = qmul(ny, in_side.v2y);

    c_nxt[1]        = c_r[0];
    c_nxt[1].nv1    = qadd(c_r[0].pa, c_r[0].pb);
    c_nxt[1].nv2    = qadd(c_r[0].pc, c_r[0].pd);
    c_nxt[1].newton = qneg(c_r[0].kn);

    c_nxt[2]       = c_r[1];
    c_nxt[2].nv2sq = qmul(c_r[1].nv2, c_r[1].nv2);
    c_nxt[2].dv    = qsub(qscale(c_r[1].nv1, 4'sd4), qscale(c_r[1].nv2, 4'sd3));

    c_nxt[3]     = c_r[2];
    c_nxt[3].br0 = qmul(C_THREE_HALVES, c_r[2].nv2sq);
    c_nxt[3].cvv = qmul(c_r[2].k, c_r[2].dv);

    c_nxt[4]    = c_r[3];
    c_nxt[4].br = qsub(qadd(qsub(c_r[3].br0, c_r[3].v1s), qscale(c_r[3].cv, 4'sd4)),
                       qscale(c_r[3].v2s, 4'sd2));
    c_nxt[4].pv = qmul(c_r[3].cvv, c_r[3].vc);

    c_nxt[5]     = c_r[4];
    c_nxt[5].kbr = qmul(c_r[4].k, c_r[4].br);

    c_nxt[6]    = c_r[5];
    c_nxt[6].cn = qadd(c_r[5].a12, c_r[5].kbr);

    c_nxt[7]     = c_r[6];
    c_nxt[7].pn1 = qmul(c_r[6].cn, c_r[6].nc);

    c_nxt[8]    = c_r[7];
    c_nxt[8].sm = qadd(c_r[7].pn1, c_r[7].pv);

    c_nxt[9]    = c_r[8];
    c_nxt[9].pn = qmul(c_r[8].icc, c_r[8].sm);

    out_nxt.accel           = c_r[9].zero ? '0 : qadd(c_r[9].newton, c_r[9].pn);
    out_nxt.zero_separation = c_r[9].zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[BACK_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < BACK_LAT - 1; i++) begin
      c_r[i] <= c_nxt[i];
    end
    out_r <= out_nxt;
  end

  assign out_valid = vld_r[BACK_LAT-1];
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== sv/post_newtonian_pair_acceleration_core.sv =====
// A result strobes out_valid after front, root, middle, divider and back stages.
// Throughput: one item per cycle; busy only rises in reset.
// Depth is set by the 32-stage square root and the 34-stage divider pipelines.
// Reset clears all valid bits and loads G and 1/c^2 with 1.0.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
// post_newtonian_pair_acceleration_core
// One axis of body one's acceleration, Newtonian plus 1PN, fully pipelined.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module post_newtonian_pair_acceleration_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  pnpa_pkg::pnpa_in_t           in_data,
  output logic                         out_valid,
  output pnpa_pkg::pnpa_out_t          out_data,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [pnpa_pkg::CFG_W-1:0]   cfg_wdata
);
  import pnpa_pkg::*;

  logic [CFG_W-1:0] grav_r, icc_r;

  logic             fr_valid;
  side_t            fr_side;
  logic [63:0]      fr_sum;
  logic [32:0]      root;
  q_t               root_q;

  side_t               side_sq_r [SQRT_LAT];
  logic [SQRT_LAT-1:0] vsq_r;
  side_t               side1_r, side2_r;
  logic                v1_r, v2_r;
  q_t                  r1_r, r2a_r, rr_r, rr2_r, rr3_r;
  side_t               side_dv_r [DIV_LAT];
  logic [DIV_LAT-1:0]  vdv_r;

  q_t nx, ny, kq, a1q, a2q;

  assign busy = ~rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= CFG_ONE;
      icc_r  <= CFG_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRAV:   grav_r <= cfg_wdata;
        REG_INV_C2: icc_r  <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  pnpa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .in_data   (in_data),
    .grav      (grav_r),
    .inv_c2    (icc_r),
    .out_valid (fr_valid),
    .out_side  (fr_side),
    .out_sum   (fr_sum)
  );

  pnpa_isqrt u_isqrt (
    .clk      (clk),
    .radicand (fr_sum),
    .root     (root)
  );

  assign root_q = (root > 33'h0_7fff_ffff) ? Q_MAX : signed'(root[31:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsq_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      vdv_r <= '0;
    end else begin
      vsq_r <= {vsq_r[SQRT_LAT-2:0], fr_valid};
      v1_r  <= vsq_r[SQRT_LAT-1];
      v2_r  <= v1_r;
      vdv_r <= {vdv_r[DIV_LAT-2:0], v2_r};
    end
  end

  always_ff @(posedge clk) begin
    side_sq_r[0] <= fr_side;
    for (int i = 1; i < SQRT_LAT; i++) begin
      side_sq_r[i] <= side_sq_r[i-1];
    end

    // r and r^2, then r^3
    side1_r <= side_sq_r[SQRT_LAT-1];
    r1_r    <= root_q;
    r2a_r   <= qmul(root_q, root_q);

    side2_r <= side1_r;
    rr_r    <= r1_r;
    rr2_r   <= r2a_r;
    rr3_r   <= qmul(r2a_r, r1_r);

    side_dv_r[0] <= side2_r;
    for (int i = 1; i < DIV_LAT; i++) begin
      side_dv_r[i] <= side_dv_r[i-1];
    end
  end

  pnpa_qdiv u_div_nx (.clk(clk), .num(side2_r.dx),  .den(rr_r),  .quo(nx));
  pnpa_qdiv u_div_ny (.clk(clk), .num(side2_r.dy),  .den(rr_r),  .quo(ny));
  pnpa_qdiv u_div_k  (.clk(clk), .num(side2_r.gm2), .den(rr2_r), .quo(kq));
  pnpa_qdiv u_div_a1 (.clk(clk), .num(side2_r.a1n), .den(rr3_r), .quo(a1q));
  pnpa_qdiv u_div_a2 (.clk(clk), .num(side2_r.a2n), .den(rr3_r), .quo(a2q));

  pnpa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vdv_r[DIV_LAT-1]),
    .in_side   (side_dv_r[DIV_LAT-1]),
    .nx        (nx),
    .ny        (ny),
    .k         (kq),
    .a1        (a1q),
    .a2        (a2q),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `PNPA_ASSERT(a_beat_latency, (start && !busy) |-> ##LATENCY out_valid, "beat lost in pipeline")
  `PNPA_ASSERT(a_no_spurious, out_valid |-> $past(start && !busy, LATENCY), "result without beat")
  `PNPA_ASSERT(a_div_align, vdv_r[DIV_LAT-1] |-> $past(vsq_r[SQRT_LAT-1], MID_LAT + DIV_LAT), "divider side data misaligned")
  `PNPA_NEVER(a_zero_clean, out_valid && out_data.zero_separation && (out_data.accel != '0), "zero separation with non-zero accel")

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the 1PN pair acceleration core: a directed table,
// then bursty random items, each checked against a predictor or a fixed value.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import pnpa_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN    = LATENCY + 20;
  localparam int N_ITEMS  = 1750;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  pnpa_in_t            in_data = '0;
  logic                out_valid;
  pnpa_out_t           out_data;
  logic                cfg_we = 1'b0;
  logic [0:0]          cfg_index = REG_GRAV;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  post_newtonian_pair_acceleration_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    pnpa_in_t  beat;
    logic      has_fixed;
    pnpa_out_t fixed;
  } row_t;

  longint      grav_model;
  longint      icc_model;
  pnpa_out_t   accel_q[$];
  int          n_fail;
  int          idle_cycles;

  function automatic longint sat_l(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return sat_l((a * b) >>> FRAC_BITS);
  endfunction

  function automatic longint fdiv(longint a, longint b);
    logic neg;
    longint ua, ub, q;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    if (ua == 0) return 0;
    if (ub == 0) return a < 0 ? -64'sd2147483648 : 64'sd2147483647;
    q = (ua <<< FRAC_BITS) / ub;
    if (q > 64'sd2147483648) q = 64'sd2147483648;
    return sat_l(neg ? -q : q);
  endfunction

  function automatic longint root_floor(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic pnpa_out_t pair_accel(pnpa_in_t b);
    longint p1x, p1y, p2x, p2y, v1x, v1y, v2x, v2y, m1, m2, dx, dy, r, r2, r3;
    longint nx, ny, vx, vy, v1s, v2s, cv, nv1, nv2, nc, vc, g2, k, nwt;
    longint a1, a2, br, cn, cvv, pn;
    logic [63:0] s;
    pnpa_out_t o;
    p1x = b.pos1_x; p1y = b.pos1_y; p2x = b.pos2_x; p2y = b.pos2_y;
    v1x = b.vel1_x; v1y = b.vel1_y; v2x = b.vel2_x; v2y = b.vel2_y;
    m1 = longint'(b.mass1);
    m2 = longint'(b.mass2);
    o = '0;
    if (p1x == p2x && p1y == p2y) begin
      o.zero_separation = 1'b1;
      return o;
    end
    dx = sat_l(p1x - p2x);
    dy = sat_l(p1y - p2y);
    s = 64'(dx * dx) + 64'(dy * dy);
    r = sat_l(root_floor(s));
    r2 = fmul(r, r);
    r3 = fmul(r2, r);
    nx = fdiv(dx, r);
    ny = fdiv(dy, r);
    vx = sat_l(v1x - v2x);
    vy = sat_l(v1y - v2y);
    v1s = sat_l(fmul(v1x, v1x) + fmul(v1y, v1y));
    v2s = sat_l(fmul(v2x, v2x) + fmul(v2y, v2y));
    cv = sat_l(fmul(v1x, v2x) + fmul(v1y, v2y));
    nv1 = sat_l(fmul(nx, v1x) + fmul(ny, v1y));
    nv2 = sat_l(fmul(nx, v2x) + fmul(ny, v2y));
    nc = (b.axis == AXIS_Y) ? ny : nx;
    vc = (b.axis == AXIS_Y) ? vy : vx;
    g2 = fmul(grav_model, grav_model);
    k = fdiv(fmul(grav_model, m2), r2);
    nwt = sat_l(-fmul(k, nc));
    a1 = fdiv(sat_l(5 * fmul(fmul(g2, m1), m2)), r3);
    a2 = fdiv(sat_l(4 * fmul(fmul(g2, m2), m2)), r3);
    br = fmul(longint'(C_THREE_HALVES), fmul(nv2, nv2));
    br = sat_l(sat_l(sat_l(br - v1s) + sat_l(4 * cv)) - sat_l(2 * v2s));
    cn = sat_l(sat_l(a1 + a2) + fmul(k, br));
    cvv = fmul(k, sat_l(sat_l(4 * nv1) - sat_l(3 * nv2)));
    pn = fmul(icc_model, sat_l(fmul(cn, nc) + fmul(cvv, vc)));
    o.accel = q_t'(sat_l(nwt + pn));
    return o;
  endfunction

  function automatic q_t rand_q();
    case ($urandom_range(0, 5))
      0: return q_t'($urandom_range(0, 4)) - 2;
      1: return $urandom() & 32'h0003ffff;
      2: return -($urandom() & 32'h0003ffff);
      3: return ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
      default: return q_t'($urandom());
    endcase
  endfunction

  function automatic pnpa_in_t rand_beat();
    pnpa_in_t b;
    b.pos1_x = rand_q(); b.pos1_y = rand_q();
    b.pos2_x = rand_q(); b.pos2_y = rand_q();
    if ($urandom_range(0, 15) == 0) begin
      b.pos2_x = b.pos1_x;
      b.pos2_y = b.pos1_y;
    end else if ($urandom_range(0, 7) == 0) begin
      b.pos2_x = b.pos1_x + q_t'($urandom_range(0, 3));
      b.pos2_y = b.pos1_y;
    end
    b.vel1_x = rand_q(); b.vel1_y = rand_q();
    b.vel2_x = rand_q(); b.vel2_y = rand_q();
    b.mass1 = ($urandom_range(0, 2) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 1 << 18));
    b.mass2 = ($urandom_range(0, 2) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 1 << 18));
    b.axis = 2'($urandom_range(0, 3));
    return b;
  endfunction

  function automatic pnpa_in_t mk(q_t p1x, q_t p1y, q_t p2x, q_t p2y, q_t vv,
                                  logic [30:0] m, logic [1:0] ax);
    pnpa_in_t b;
    b.pos1_x = p1x; b.pos1_y = p1y; b.pos2_x = p2x; b.pos2_y = p2y;
    b.vel1_x = vv; b.vel1_y = -vv; b.vel2_x = -vv; b.vel2_y = vv;
    b.mass1 = m; b.mass2 = m; b.axis = ax;
    return b;
  endfunction

  // results
  always @(posedge clk) begin
    pnpa_out_t exp_o;
    if (rst_n && out_valid) begin
      if (accel_q.size() == 0) begin
        $error("unexpected result accel=%0d", out_data.accel);
        n_fail++;
      end else begin
        exp_o = accel_q.pop_front();
        if (out_data.accel !== exp_o.accel) begin
          $error("accel: expected %0d, got %0d", exp_o.accel, out_data.accel);
          n_fail++;
        end
        if (out_data.zero_separation !== exp_o.zero_separation) begin
          $error("zero_separation: expected %0b, got %0b",
                 exp_o.zero_separation, out_data.zero_separation);
          n_fail++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic cfg_write(logic [0:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_GRAV) grav_model = longint'(val);
    else icc_model = longint'(val);
  endtask

  task automatic wait_drained();
    while (accel_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // holds the beat until accepted; start stays high if another beat follows
  task automatic send_beat(pnpa_in_t b, pnpa_out_t exp_o, logic more);
    start <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy);
    accel_q.push_back(exp_o);
    if (!more) start <= 1'b0;
  endtask

  // the last beat of a burst drops start, and a gap follows every burst
  task automatic run_random(int n);
    int burst;
    pnpa_in_t b;
    while (n > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && n > 0) begin
        b = rand_beat();
        send_beat(b, pair_accel(b), burst > 1 && n > 1);
        burst--;
        n--;
      end
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  row_t rows[$];
  row_t rw;
  pnpa_out_t zero_res;
  pnpa_out_t pred;

  initial begin
    n_fail = 0;
    idle_cycles = 0;
    grav_model = longint'(CFG_ONE);
    icc_model = longint'(CFG_ONE);
    zero_res = '0;
    zero_res.zero_separation = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // coinciding bodies
    rw.beat = mk(32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000, 31'h10000, 2'd1);
    rw.has_fixed = 1'b1; rw.fixed = zero_res; rows.push_back(rw);
    rw.beat = mk(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, '1, 2'd2); rows.push_back(rw);
    // zero masses, no velocity: nothing pulls
    rw.beat = mk(32'sh10000, 0, 0, 0, 0, 31'd0, 2'd1);
    rw.has_fixed = 1'b1; rw.fixed = '0; rows.push_back(rw);
    rw.has_fixed = 1'b0;
    rw.beat = mk(32'sh10000, 0, 0, 0, 0, 31'h10000, 2'd1); rows.push_back(rw);
    rw.beat = mk(0, 32'sh20000, 0, 0, 32'sh8000, 31'h10000, 2'd2); rows.push_back(rw);
    rw.beat = mk(32'sh10000, 32'sh10000, 0, 0, 32'sh4000, 31'h8000, 2'd0); rows.push_back(rw);
    rw.beat = mk(32'sh10000, 32'sh10000, 0, 0, 32'sh4000, 31'h8000, 2'd3); rows.push_back(rw);
    // tiny separation: r^2 and r^3 round to zero
    rw.beat = mk(1, 0, 0, 0, 32'sh100, 31'h10000, 2'd1); rows.push_back(rw);
    rw.beat = mk(0, 0, 0, 2, 32'sh100, 31'h10000, 2'd2); rows.push_back(rw);
    rw.beat = mk(Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MAX, '1, 2'd1); rows.push_back(rw);
    rw.beat = mk(Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN, '1, 2'd2); rows.push_back(rw);
    rw.beat = mk(-1, -1, 0, 0, -1, 31'd1, 2'd1); rows.push_back(rw);
    rw.beat = mk(Q_MAX, 0, 0, 0, 0, 31'h10000, 2'd1); rows.push_back(rw);

    foreach (rows[i]) begin
      pred = pair_accel(rows[i].beat);
      send_beat(rows[i].beat, rows[i].has_fixed ? rows[i].fixed : pred, i < rows.size() - 1);
    end
    wait_drained();

    cfg_write(REG_GRAV, '1);
    cfg_write(REG_INV_C2, '0);
    run_random(N_ITEMS / 5);
    wait_drained();
    cfg_write(REG_GRAV, '0);
    cfg_write(REG_INV_C2, '1);
    run_random(N_ITEMS / 5);
    wait_drained();
    cfg_write(REG_GRAV, 31'h4000);
    cfg_write(REG_INV_C2, 31'h100);
    run_random(N_ITEMS / 5);
    wait_drained();
    cfg_write(REG_GRAV, 31'($urandom()));
    cfg_write(REG_INV_C2, 31'($urandom_range(0, 1 << 17)));
    run_random(N_ITEMS / 5);
    wait_drained();
    cfg_write(REG_GRAV, CFG_ONE);
    cfg_write(REG_INV_C2, CFG_ONE);
    run_random(N_ITEMS / 5);
    wait_drained();

    if (n_fail == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
